/* rtl/lapwm_pkg.sv */
package lapwm_pkg;

    localparam int NUM_CH       = 6;
    localparam int PHASES       = 64;
    localparam int NUM_PATTERNS = 7;
    localparam int PWM_PERIOD   = 255;
    localparam int BAND_STRIDE  = 10;
    localparam int VOLT_W       = 13;

    localparam logic [1:0] REG_TICKS_PER_FRAME   = 2'd0;
    localparam logic [1:0] REG_WARN_THRESHOLD_MV = 2'd1;
    localparam logic [1:0] REG_CHARGE_OFFSET_MV  = 2'd2;
    localparam logic [1:0] REG_WRAPS_PER_PATTERN = 2'd3;

    localparam logic [2:0] PAT_CHASE_UP   = 3'd0;
    localparam logic [2:0] PAT_CHASE_DOWN = 3'd1;
    localparam logic [2:0] PAT_BREATHE    = 3'd2;
    localparam logic [2:0] PAT_BANDS      = 3'd3;
    localparam logic [2:0] PAT_INVERTED   = 3'd4;
    localparam logic [2:0] PAT_BLINK      = 3'd5;
    localparam logic [2:0] PAT_SINGLE     = 3'd6;
    localparam logic [2:0] PAT_LAST       = PAT_SINGLE;

    typedef logic [7:0] level_t;
    typedef level_t [NUM_CH-1:0] level_array_t;

    function automatic level_t gamma_lookup(input logic [5:0] idx);
        level_t g;
        case (idx)
            6'd0: g = 8'd0;      6'd1: g = 8'd1;      6'd2: g = 8'd2;      6'd3: g = 8'd2;
            6'd4: g = 8'd2;      6'd5: g = 8'd3;      6'd6: g = 8'd3;      6'd7: g = 8'd4;
            6'd8: g = 8'd5;      6'd9: g = 8'd6;      6'd10: g = 8'd7;     6'd11: g = 8'd8;
            6'd12: g = 8'd10;    6'd13: g = 8'd11;    6'd14: g = 8'd13;    6'd15: g = 8'd16;
            6'd16: g = 8'd19;    6'd17: g = 8'd23;    6'd18: g = 8'd27;    6'd19: g = 8'd32;
            6'd20: g = 8'd38;    6'd21: g = 8'd45;    6'd22: g = 8'd54;    6'd23: g = 8'd64;
            6'd24: g = 8'd76;    6'd25: g = 8'd91;    6'd26: g = 8'd108;   6'd27: g = 8'd128;
            6'd28: g = 8'd152;   6'd29: g = 8'd181;   6'd30: g = 8'd215;   6'd31: g = 8'd255;
            6'd32: g = 8'd215;   6'd33: g = 8'd181;   6'd34: g = 8'd152;   6'd35: g = 8'd128;
            6'd36: g = 8'd108;   6'd37: g = 8'd91;    6'd38: g = 8'd76;    6'd39: g = 8'd64;
            6'd40: g = 8'd54;    6'd41: g = 8'd45;    6'd42: g = 8'd38;    6'd43: g = 8'd32;
            6'd44: g = 8'd27;    6'd45: g = 8'd23;    6'd46: g = 8'd19;    6'd47: g = 8'd16;
            6'd48: g = 8'd13;    6'd49: g = 8'd11;    6'd50: g = 8'd10;    6'd51: g = 8'd8;
            6'd52: g = 8'd7;     6'd53: g = 8'd6;     6'd54: g = 8'd5;     6'd55: g = 8'd4;
            6'd56: g = 8'd3;     6'd57: g = 8'd3;     6'd58: g = 8'd2;     6'd59: g = 8'd2;
            6'd60: g = 8'd2;     6'd61: g = 8'd1;     6'd62: g = 8'd0;     6'd63: g = 8'd0;
            default: g = 8'd0;
        endcase
        return g;
    endfunction

endpackage

/* rtl/lapwm_levels.sv */
module lapwm_levels (
    input  logic [5:0]              phase,
    input  logic [2:0]              pattern,
    output lapwm_pkg::level_array_t levels
);
    import lapwm_pkg::*;

    always_comb begin
        logic       odd;
        logic [5:0] chan_off;
        logic [5:0] band;
        odd  = phase[0];
        band = '0;
        chan_off = '0;
        band[0] = phase < 6'd6;
        band[1] = (phase >= 6'd6 && phase < 6'd12) || phase >= 6'd56;
        band[2] = (phase >= 6'd12 && phase < 6'd18) || (phase >= 6'd50 && phase < 6'd56);
        band[3] = (phase >= 6'd16 && phase < 6'd24) || (phase >= 6'd44 && phase < 6'd50);
        band[4] = (phase >= 6'd24 && phase < 6'd30) || (phase >= 6'd38 && phase < 6'd44);
        band[5] = phase >= 6'd30 && phase < 6'd38;
        for (int i = 0; i < NUM_CH; i++) begin
            case (pattern)
                PAT_CHASE_UP: begin
                    chan_off  = 6'(BAND_STRIDE * i);
                    levels[i] = gamma_lookup(phase + chan_off);
                end
                PAT_CHASE_DOWN: begin
                    chan_off  = 6'(BAND_STRIDE * (NUM_CH - 1 - i));
                    levels[i] = gamma_lookup(phase + chan_off);
                end
                PAT_BREATHE: begin
                    levels[i] = gamma_lookup(phase);
                end
                PAT_BANDS: begin
                    levels[i] = (odd && band[i]) ? 8'hFF : 8'h00;
                end
                PAT_INVERTED: begin
                    chan_off  = 6'(BAND_STRIDE * i);
                    levels[i] = ~gamma_lookup(phase + chan_off);
                end
                PAT_BLINK: begin
                    levels[i] = odd ? 8'hFF : 8'h00;
                end
                PAT_SINGLE: begin
                    levels[i] = (phase == 6'(i)) ? 8'hFF : 8'h00;
                end
                default: begin
                    levels[i] = 8'h00;
                end
            endcase
        end
    end

endmodule

/* rtl/led_animation_pwm_sequencer_core.sv */
// LED animation sequencer with six PWM channels and a battery monitor.
// Each request on the s_ channel is one tick: battery voltage, charging flag and
// button flag. Every accepted tick produces exactly one result on the m_ channel:
// the six PWM outputs, the low-battery warning, the running average voltage, the
// active animation pattern and the halted flag.
// Ticks are taken at one per clock cycle unless the receiver stalls; the result appears in
// the output register in the cycle after the tick is accepted. All tick processing is one
// registered pass of compare, add and table logic; the average is read out of
// the registered sample sum through a constant reciprocal multiplier.
// The sample history is a memory of AVG_DEPTH entries whose next entry is
// fetched ahead of time, so it is ready at each wrap; the memory needs no clearing pass.
// When the receiver stalls, the output register holds its result and s_tready
// drops until the result is taken; a new tick is accepted in the same cycle the
// waiting result leaves.
// Registers are written via the cfg_ channel (always ready), by the user only while idle;
// the block does not enforce this. Reset is synchronous and active low; it restores the
// register defaults and clears all sequencing state. The first tick after reset primes the
// average. A button press turns every output off and freezes the block until reset.
module led_animation_pwm_sequencer_core #(
    parameter int AVG_DEPTH = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    // s_tdata: voltage_mv[12:0], charging[13], button_pressed[14], zero[15]
    input  logic [15:0] s_tdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    // m_tdata: led_drive[5:0], warn_led[6], average_mv[19:7], pattern[22:20],
    // halted[23]
    output logic [23:0] m_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [12:0] cfg_data
);
    import lapwm_pkg::*;

    localparam int PTR_W     = $clog2(AVG_DEPTH);
    localparam int SUM_W     = VOLT_W + PTR_W;
    localparam int DIV_SHIFT = SUM_W + PTR_W;
    localparam int RECIP_W   = SUM_W + 1;
    localparam logic [63:0] RECIP64 =
        ((64'd1 << DIV_SHIFT) + 64'(AVG_DEPTH) - 64'd1) / 64'(AVG_DEPTH);
    localparam logic [RECIP_W-1:0] RECIP = RECIP64[RECIP_W-1:0];
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(AVG_DEPTH - 1);

    logic [11:0] ticks_per_frame_reg;
    logic [12:0] warn_threshold_reg;
    logic [12:0] charge_offset_reg;
    logic [7:0]  wraps_per_pattern_reg;

    logic [11:0]        tick_reg, tick_next;
    logic [5:0]         phase_reg, phase_next;
    logic [2:0]         pattern_reg, pattern_next;
    logic [7:0]         wrap_reg, wrap_next;
    level_array_t       level_reg, level_next, level_calc;
    logic [NUM_CH-1:0]  on_reg, on_next;
    logic [PTR_W-1:0]   ptr_reg, ptr_next, ptr_inc;
    logic [SUM_W-1:0]   sum_reg, sum_next;
    logic               warning_reg, warning_next;
    logic               primed_reg, primed_next;
    logic               stopped_reg, stopped_next;
    logic [VOLT_W-1:0]  prime_reg, prime_next;
    logic               full_reg, full_next;
    logic [VOLT_W-1:0]  rd_reg;
    logic [VOLT_W-1:0]  ring_mem [AVG_DEPTH];
    logic               ring_we;
    logic [VOLT_W-1:0]  adj_sample;

    logic [NUM_CH-1:0]  out_led_reg;
    logic               out_warn_reg;
    logic [SUM_W-1:0]   out_sum_reg;
    logic [2:0]         out_pattern_reg;
    logic               out_halted_reg;
    logic               m_valid_reg;

    logic [VOLT_W-1:0]  in_voltage;
    logic               in_charging;
    logic               in_button;
    logic               accept;

    logic [SUM_W+RECIP_W-1:0] avg_product;

    assign in_voltage  = s_tdata[12:0];
    assign in_charging = s_tdata[13];
    assign in_button   = s_tdata[14];

    assign s_tready  = !m_valid_reg || m_tready;
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign ptr_inc   = (ptr_reg == PTR_LAST) ? '0 : ptr_reg + 1'b1;

    lapwm_levels u_levels (
        .phase   (phase_next),
        .pattern (pattern_next),
        .levels  (level_calc)
    );

    always_comb begin
        logic [12:0]       tick_inc;
        logic [8:0]        wrap_inc;
        logic              frame_end;
        logic              wrap;
        logic [SUM_W-1:0]  sum_cur;
        logic [VOLT_W-1:0] prime_cur;
        logic [VOLT_W-1:0] old_sample;
        logic [8:0]        step_sum;
        logic [7:0]        step;

        tick_next    = tick_reg;
        phase_next   = phase_reg;
        pattern_next = pattern_reg;
        wrap_next    = wrap_reg;
        level_next   = level_reg;
        on_next      = on_reg;
        ptr_next     = ptr_reg;
        sum_next     = sum_reg;
        warning_next = warning_reg;
        primed_next  = primed_reg;
        stopped_next = stopped_reg;
        prime_next   = prime_reg;
        full_next    = full_reg;
        ring_we      = 1'b0;
        step_sum     = '0;
        step         = '0;

        if (in_charging) begin
            adj_sample = (in_voltage > charge_offset_reg) ? in_voltage - charge_offset_reg
                                                          : '0;
        end else begin
            adj_sample = in_voltage;
        end

        sum_cur   = primed_reg ? sum_reg : SUM_W'(32'(in_voltage) * AVG_DEPTH);
        prime_cur = primed_reg ? prime_reg : in_voltage;
        tick_inc  = {1'b0, tick_reg} + 13'd1;
        frame_end = tick_inc >= {1'b0, ticks_per_frame_reg};
        wrap      = frame_end && (phase_reg == 6'(PHASES - 1));
        wrap_inc  = {1'b0, wrap_reg} + 9'd1;
        old_sample = full_reg ? rd_reg : prime_cur;

        if (accept && !stopped_reg) begin
            primed_next = 1'b1;
            prime_next  = prime_cur;
            sum_next    = sum_cur;
            if (frame_end) begin
                tick_next  = '0;
                phase_next = phase_reg + 6'd1;
                if (wrap) begin
                    ring_we      = 1'b1;
                    ptr_next     = ptr_inc;
                    sum_next     = sum_cur - SUM_W'(old_sample) + SUM_W'(adj_sample);
                    warning_next = (adj_sample < warn_threshold_reg) && !in_charging;
                    if (ptr_inc == '0) begin
                        full_next = 1'b1;
                    end
                    if (wrap_inc >= {1'b0, wraps_per_pattern_reg}) begin
                        wrap_next    = '0;
                        pattern_next = (pattern_reg == PAT_LAST) ? PAT_CHASE_UP
                                                                 : pattern_reg + 3'd1;
                    end else begin
                        wrap_next = wrap_inc[7:0];
                    end
                end
                level_next = level_calc;
            end else begin
                tick_next = tick_inc[11:0];
            end

            // 256 is congruent to 1 modulo 255, so the high nibble folds onto the low byte.
            step_sum = {1'b0, tick_next[7:0]} + {5'd0, tick_next[11:8]};
            step     = (step_sum >= 9'(PWM_PERIOD)) ? 8'(step_sum - 9'(PWM_PERIOD))
                                                    : step_sum[7:0];
            for (int i = 0; i < NUM_CH; i++) begin
                if (step == 8'd0 && level_next[i] != 8'd0) begin
                    on_next[i] = 1'b1;
                end
                if (step == level_next[i]) begin
                    on_next[i] = 1'b0;
                end
            end

            if (in_button) begin
                stopped_next = 1'b1;
                on_next      = '0;
                warning_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ticks_per_frame_reg   <= 12'd2560;
            warn_threshold_reg    <= 13'd3600;
            charge_offset_reg     <= 13'd500;
            wraps_per_pattern_reg <= 8'd16;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_TICKS_PER_FRAME:   ticks_per_frame_reg   <= cfg_data[11:0];
                REG_WARN_THRESHOLD_MV: warn_threshold_reg    <= cfg_data;
                REG_CHARGE_OFFSET_MV:  charge_offset_reg     <= cfg_data;
                REG_WRAPS_PER_PATTERN: wraps_per_pattern_reg <= cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_reg    <= '0;
            phase_reg   <= '0;
            pattern_reg <= '0;
            wrap_reg    <= '0;
            level_reg   <= '0;
            on_reg      <= '0;
            ptr_reg     <= '0;
            sum_reg     <= '0;
            warning_reg <= 1'b0;
            primed_reg  <= 1'b0;
            stopped_reg <= 1'b0;
            full_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            tick_reg    <= tick_next;
            phase_reg   <= phase_next;
            pattern_reg <= pattern_next;
            wrap_reg    <= wrap_next;
            level_reg   <= level_next;
            on_reg      <= on_next;
            ptr_reg     <= ptr_next;
            sum_reg     <= sum_next;
            warning_reg <= warning_next;
            primed_reg  <= primed_next;
            stopped_reg <= stopped_next;
            full_reg    <= full_next;
            if (accept) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // The entry to be replaced at the next wrap is fetched every cycle.
    always_ff @(posedge aclk) begin
        if (ring_we) begin
            ring_mem[ptr_inc] <= adj_sample;
        end
        rd_reg <= ring_mem[ptr_inc];
    end

    always_ff @(posedge aclk) begin
        prime_reg <= prime_next;
        if (accept) begin
            out_led_reg     <= on_next;
            out_warn_reg    <= warning_next;
            out_sum_reg     <= sum_next;
            out_pattern_reg <= pattern_next;
            out_halted_reg  <= stopped_next;
        end
    end

    assign avg_product = {{RECIP_W{1'b0}}, out_sum_reg} * {{SUM_W{1'b0}}, RECIP};

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {out_halted_reg, out_pattern_reg, avg_product[DIV_SHIFT +: VOLT_W],
                       out_warn_reg, out_led_reg};

    a_halt_dark: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && out_halted_reg |-> out_led_reg == '0 && !out_warn_reg)
        else $error("halted result shows a lit output");

    a_halt_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        stopped_reg |=> stopped_reg && $stable(sum_reg) && $stable(pattern_reg))
        else $error("state changed after halt");

    a_pattern_range: assert property (@(posedge aclk) disable iff (!aresetn)
        pattern_reg <= PAT_LAST)
        else $error("pattern index out of range");

    a_ptr_range: assert property (@(posedge aclk) disable iff (!aresetn)
        ptr_reg <= PTR_LAST)
        else $error("ring pointer out of range");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_tready |=> m_valid_reg && $stable(out_sum_reg))
        else $error("stalled result changed");

endmodule

/* test/tb_led_animation_pwm_sequencer_core.sv */
module tb_led_animation_pwm_sequencer_core;

    import lapwm_pkg::*;

    localparam int HIST_DEPTH = 32;
    localparam int STALL_LIMIT = 3000;
    localparam int ITEM_BUDGET = 1080;

    localparam logic [8*PHASES-1:0] GAMMA_BITS = {
        8'd0, 8'd1, 8'd2, 8'd2, 8'd2, 8'd3, 8'd3, 8'd4, 8'd5, 8'd6, 8'd7, 8'd8, 8'd10, 8'd11,
        8'd13, 8'd16, 8'd19, 8'd23, 8'd27, 8'd32, 8'd38, 8'd45, 8'd54, 8'd64, 8'd76,
        8'd91, 8'd108, 8'd128, 8'd152, 8'd181, 8'd215, 8'd255,
        8'd215, 8'd181, 8'd152, 8'd128, 8'd108, 8'd91,
        8'd76, 8'd64, 8'd54, 8'd45, 8'd38, 8'd32, 8'd27, 8'd23, 8'd19, 8'd16, 8'd13,
        8'd11, 8'd10, 8'd8, 8'd7, 8'd6, 8'd5, 8'd4, 8'd3, 8'd3, 8'd2, 8'd2, 8'd2, 8'd1,
        8'd0, 8'd0};

    typedef struct packed {
        logic        halted;
        logic [2:0]  pattern;
        logic [12:0] average;
        logic        warn;
        logic [5:0]  led;
    } tick_out_t;

    logic        aclk;
    logic        aresetn;
    logic [15:0] s_tdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] m_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [12:0] cfg_data;

    logic [11:0] cfg_frame_len = 12'd2560;
    logic [12:0] cfg_warn_mv   = 13'd3600;
    logic [12:0] cfg_chg_off   = 13'd500;
    logic [7:0]  cfg_pat_len   = 8'd16;

    logic [11:0] frame_ticks = '0;
    logic [5:0]  phase_q     = '0;
    logic [2:0]  pattern_q   = '0;
    logic [7:0]  wrap_cnt    = '0;
    logic [7:0]  level_q [NUM_CH];
    logic [5:0]  drive_q     = '0;
    logic [12:0] hist [HIST_DEPTH];
    int          hist_ptr    = 0;
    logic [17:0] hist_sum    = '0;
    logic [12:0] avg_q       = '0;
    logic        warn_q      = 1'b0;
    logic        primed_q    = 1'b0;
    logic        halted_q    = 1'b0;

    tick_out_t   due_outputs [$];
    int          mismatches  = 0;
    int          sent_count  = 0;
    int          quiet_cycles = 0;
    bit          tx_gaps_on  = 1'b1;
    bit          rx_stalls_on = 1'b1;
    int          rx_hold_len = 0;

    led_animation_pwm_sequencer_core #(
        .AVG_DEPTH(HIST_DEPTH)
    ) u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    initial begin
        for (int k = 0; k < NUM_CH; k++) begin
            level_q[k] = '0;
        end
    end

    function automatic logic [7:0] gamma_at(int idx);
        int j;
        j = idx & (PHASES - 1);
        return GAMMA_BITS[(PHASES - 1 - j) * 8 +: 8];
    endfunction

    function automatic void refresh_levels();
        int x;
        logic odd;
        int k;
        x = phase_q;
        odd = phase_q[0];
        case (pattern_q)
            PAT_CHASE_UP: begin
                for (k = 0; k < NUM_CH; k++) level_q[k] = gamma_at(x + BAND_STRIDE * k);
            end
            PAT_CHASE_DOWN: begin
                for (k = 0; k < NUM_CH; k++) begin
                    level_q[k] = gamma_at(x + BAND_STRIDE * (NUM_CH - 1 - k));
                end
            end
            PAT_BREATHE: begin
                for (k = 0; k < NUM_CH; k++) level_q[k] = gamma_at(x);
            end
            PAT_BANDS: begin
                level_q[0] = {8{odd && x < 6}};
                level_q[1] = {8{odd && ((x >= 6 && x < 12) || x >= 56)}};
                level_q[2] = {8{odd && ((x >= 12 && x < 18) || (x >= 50 && x < 56))}};
                level_q[3] = {8{odd && ((x >= 16 && x < 24) || (x >= 44 && x < 50))}};
                level_q[4] = {8{odd && ((x >= 24 && x < 30) || (x >= 38 && x < 44))}};
                level_q[5] = {8{odd && (x >= 30 && x < 38)}};
            end
            PAT_INVERTED: begin
                for (k = 0; k < NUM_CH; k++) level_q[k] = ~gamma_at(x + BAND_STRIDE * k);
            end
            PAT_BLINK: begin
                for (k = 0; k < NUM_CH; k++) level_q[k] = {8{odd}};
            end
            PAT_SINGLE: begin
                for (k = 0; k < NUM_CH; k++) level_q[k] = {8{x == k}};
            end
            default: begin
            end
        endcase
    endfunction

    // Battery sample and pattern advance, taken once per phase wrap.
    function automatic void take_sample(logic [12:0] mv, logic chg);
        int s;
        s = mv;
        if (chg) s = (mv > cfg_chg_off) ? mv - cfg_chg_off : 0;
        hist_ptr = (hist_ptr + 1) % HIST_DEPTH;
        hist_sum = hist_sum - hist[hist_ptr] + s;
        hist[hist_ptr] = s;
        avg_q = hist_sum / HIST_DEPTH;
        warn_q = (s < cfg_warn_mv) && !chg;
        if (int'(wrap_cnt) + 1 >= int'(cfg_pat_len)) begin
            wrap_cnt = '0;
            pattern_q = (pattern_q == NUM_PATTERNS - 1) ? '0 : pattern_q + 3'd1;
        end else begin
            wrap_cnt = wrap_cnt + 8'd1;
        end
    endfunction

    function automatic tick_out_t advance_sequencer(logic [12:0] mv, logic chg, logic btn);
        tick_out_t r;
        int k;
        int step;
        if (!halted_q) begin
            if (!primed_q) begin
                for (k = 0; k < HIST_DEPTH; k++) hist[k] = mv;
                hist_sum = mv * HIST_DEPTH;
                avg_q = mv;
                primed_q = 1'b1;
            end
            if (int'(frame_ticks) + 1 >= int'(cfg_frame_len)) begin
                frame_ticks = '0;
                phase_q = phase_q + 6'd1;
                if (phase_q == '0) take_sample(mv, chg);
                refresh_levels();
            end else begin
                frame_ticks = frame_ticks + 12'd1;
            end
            step = int'(frame_ticks) % PWM_PERIOD;
            for (k = 0; k < NUM_CH; k++) begin
                if (step == 0 && level_q[k] != 0) drive_q[k] = 1'b1;
                if (step == level_q[k]) drive_q[k] = 1'b0;
            end
            if (btn) begin
                halted_q = 1'b1;
                drive_q = '0;
                warn_q = 1'b0;
            end
        end
        r.led = drive_q;
        r.warn = warn_q;
        r.average = avg_q;
        r.pattern = pattern_q;
        r.halted = halted_q;
        return r;
    endfunction

    task automatic check_result(logic [23:0] data);
        tick_out_t got;
        tick_out_t want;
        got = data;
        if (due_outputs.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %h with none pending", data);
        end else begin
            want = due_outputs.pop_front();
            if (got.led !== want.led || got.warn !== want.warn ||
                got.average !== want.average || got.pattern !== want.pattern ||
                got.halted !== want.halted) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("mismatch at %0t: expected led=%h warn=%b avg=%0d pat=%0d halt=%b",
                             $realtime, want.led, want.warn, want.average, want.pattern,
                             want.halted);
                    $display("                 got led=%h warn=%b avg=%0d pat=%0d halt=%b",
                             got.led, got.warn, got.average, got.pattern, got.halted);
                end
            end
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) check_result(m_tdata);
            if (s_tvalid && s_tready) begin
                due_outputs.push_back(advance_sequencer(s_tdata[12:0], s_tdata[13], s_tdata[14]));
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
            $display("** led_animation_pwm_sequencer_core: FAILED **");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Result receiver: random stalls, plus a long hold-off when one is requested.
    initial begin
        int gap;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (rx_hold_len > 0) begin
                m_tready = 1'b0;
                repeat (rx_hold_len) @(negedge aclk);
                rx_hold_len = 0;
            end
            gap = rx_stalls_on ? $urandom_range(0, 13) : 0;
            if (gap > 0) begin
                m_tready = 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_tready = 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    task automatic send_tick(logic [12:0] mv, logic chg, logic btn);
        int gap;
        gap = tx_gaps_on ? $urandom_range(0, 13) : 0;
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tdata = {1'b0, btn, chg, mv};
        s_tvalid = 1'b1;
        do @(posedge aclk); while (!s_tready);
        sent_count++;
    endtask

    task automatic drain();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (due_outputs.size() != 0) @(posedge aclk);
        repeat (2) @(posedge aclk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [12:0] val);
        @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            REG_TICKS_PER_FRAME:   cfg_frame_len = val[11:0];
            REG_WARN_THRESHOLD_MV: cfg_warn_mv = val;
            REG_CHARGE_OFFSET_MV:  cfg_chg_off = val;
            REG_WRAPS_PER_PATTERN: cfg_pat_len = val[7:0];
            default: begin
            end
        endcase
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    // Voltages cluster around the threshold and the charge offset to hit the edges.
    function automatic logic [12:0] pick_mv();
        case ($urandom_range(0, 7))
            0: return 13'd0;
            1: return 13'h1FFF;
            2: return cfg_warn_mv;
            3: return cfg_warn_mv - 13'd1;
            4: return cfg_chg_off;
            5: return cfg_chg_off + 13'd1;
            default: return 13'($urandom_range(0, 8191));
        endcase
    endfunction

    task automatic send_random_ticks(int n);
        for (int k = 0; k < n; k++) send_tick(pick_mv(), 1'($urandom_range(0, 1)), 1'b0);
    endtask

    task automatic test_directed();
        send_tick(13'h1FFF, 1'b1, 1'b0);
        send_tick(13'd0, 1'b0, 1'b0);
        send_tick(13'd4096, 1'b1, 1'b0);
        send_tick(13'd1, 1'b0, 1'b0);
        drain();
        write_reg(REG_TICKS_PER_FRAME, 13'd1);
        send_tick(13'd0, 1'b1, 1'b0);
        send_tick(13'h1FFF, 1'b0, 1'b0);
        send_tick(13'h1FFF, 1'b1, 1'b0);
        send_tick(13'd1, 1'b1, 1'b0);
        send_tick(13'd3599, 1'b0, 1'b0);
        send_tick(13'd3600, 1'b0, 1'b0);
        send_tick(13'd500, 1'b1, 1'b0);
        send_tick(13'd499, 1'b1, 1'b0);
        send_tick(13'h0AAA, 1'b0, 1'b0);
        send_tick(13'h1555, 1'b1, 1'b0);
        send_tick(13'd4095, 1'b0, 1'b0);
        send_tick(13'd8190, 1'b1, 1'b0);
    endtask

    task automatic test_pattern_sweep();
        drain();
        write_reg(REG_TICKS_PER_FRAME, 13'd0);
        write_reg(REG_WARN_THRESHOLD_MV, 13'h1FFF);
        write_reg(REG_CHARGE_OFFSET_MV, 13'd3000);
        write_reg(REG_WRAPS_PER_PATTERN, 13'd1);
        send_random_ticks(PHASES * NUM_PATTERNS);
    endtask

    task automatic test_lowered_limits();
        drain();
        write_reg(REG_TICKS_PER_FRAME, 13'd4095);
        send_random_ticks(40);
        drain();
        write_reg(REG_TICKS_PER_FRAME, 13'd3);
        send_random_ticks(10);
        drain();
        write_reg(REG_WRAPS_PER_PATTERN, 13'd255);
        write_reg(REG_TICKS_PER_FRAME, 13'd1);
        send_random_ticks(2 * PHASES);
        drain();
        write_reg(REG_WRAPS_PER_PATTERN, 13'd1);
        send_random_ticks(PHASES);
    endtask

    task automatic test_backpressure();
        drain();
        tx_gaps_on = 1'b0;
        rx_stalls_on = 1'b0;
        rx_hold_len = 300;
        send_random_ticks(40);
        tx_gaps_on = 1'b1;
        rx_stalls_on = 1'b1;
    endtask

    task automatic test_random_settings();
        logic [11:0] frame_len;
        logic [7:0] pat_len;
        logic [12:0] mv_a;
        logic [12:0] mv_b;
        int mode;
        while (sent_count < ITEM_BUDGET) begin
            case ($urandom_range(0, 5))
                0: frame_len = 12'd0;
                1: frame_len = 12'd1;
                2: frame_len = 12'($urandom_range(2, 4));
                3: frame_len = 12'($urandom_range(20, 300));
                4: frame_len = 12'd4095;
                default: frame_len = 12'd1;
            endcase
            case ($urandom_range(0, 3))
                0: pat_len = 8'd0;
                1: pat_len = 8'd1;
                2: pat_len = 8'($urandom_range(2, 3));
                default: pat_len = 8'd255;
            endcase
            case ($urandom_range(0, 2))
                0: mv_a = 13'd0;
                1: mv_a = 13'h1FFF;
                default: mv_a = 13'($urandom_range(0, 8191));
            endcase
            case ($urandom_range(0, 2))
                0: mv_b = 13'd0;
                1: mv_b = 13'h1FFF;
                default: mv_b = 13'($urandom_range(0, 8191));
            endcase
            drain();
            // Unused upper bits of the write data carry noise.
            write_reg(REG_TICKS_PER_FRAME, {1'($urandom_range(0, 1)), frame_len});
            write_reg(REG_WARN_THRESHOLD_MV, mv_a);
            write_reg(REG_CHARGE_OFFSET_MV, mv_b);
            write_reg(REG_WRAPS_PER_PATTERN, {5'($urandom_range(0, 31)), pat_len});
            mode = $urandom_range(0, 3);
            tx_gaps_on = mode[0];
            rx_stalls_on = mode[1];
            send_random_ticks($urandom_range(40, 160));
        end
        tx_gaps_on = 1'b1;
        rx_stalls_on = 1'b1;
    endtask

    task automatic test_button_halt();
        send_tick(pick_mv(), 1'($urandom_range(0, 1)), 1'b1);
        for (int k = 0; k < 12; k++) begin
            send_tick(pick_mv(), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        end
    endtask

    initial begin
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        cfg_valid = 1'b0;
        cfg_index = REG_TICKS_PER_FRAME;
        cfg_data = '0;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_directed();
        test_pattern_sweep();
        test_lowered_limits();
        test_backpressure();
        test_random_settings();
        test_button_halt();

        drain();
        repeat (8) @(posedge aclk);
        if (mismatches == 0 && due_outputs.size() == 0) begin
            $display("** led_animation_pwm_sequencer_core: PASSED **");
        end else begin
            $display("** led_animation_pwm_sequencer_core: FAILED **");
        end
        $finish;
    end

endmodule
